@@ rtl/core/tss_pkg.sv @@
// Shared types and constants of the side-angle-side triangle solver.
package tss_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int SIDE_BITS  = 16;
	localparam int ANGLE_BITS = 16;
	localparam int FOLD_BITS  = 15;
	localparam int C_BITS     = 17;
	localparam int PER_BITS   = 18;
	localparam int AREA_BITS  = 23;
	localparam int COS_BITS   = 31;
	localparam int ROOT_BITS  = 24;
	localparam int RAD_BITS   = 48;

	localparam logic [ANGLE_BITS-1:0] ANGLE_LIM  = ANGLE_BITS'(180 << FRAC_BITS);
	localparam logic [ANGLE_BITS-1:0] ANGLE_HALF = ANGLE_BITS'(90 << FRAC_BITS);

	// pi/180 and one, both in Q30.
	localparam logic [24:0] RAD_Q30 = 25'd18740330;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// Truncating division of a 32-bit value by the series divisors is done as a
	// multiply by a rounded-up reciprocal with 32 plus ceil(log2 k) fraction bits,
	// which is exact over the whole 32-bit range.
	localparam int HORNER_STEPS = 6;
	localparam int HORNER_SHIFT [HORNER_STEPS] = '{40, 40, 39, 38, 37, 36};
	localparam logic [32:0] HORNER_MUL [HORNER_STEPS] = '{
		33'(((64'd1 << 40) + 64'd181) / 64'd182),
		33'(((64'd1 << 40) + 64'd131) / 64'd132),
		33'(((64'd1 << 39) + 64'd89) / 64'd90),
		33'(((64'd1 << 38) + 64'd55) / 64'd56),
		33'(((64'd1 << 37) + 64'd29) / 64'd30),
		33'(((64'd1 << 36) + 64'd11) / 64'd12)
	};

	typedef struct packed {
		logic [SIDE_BITS-1:0] a;
		logic [SIDE_BITS-1:0] b;
		logic                 obtuse;
	} tss_item_t;

	typedef struct packed {
		logic [SIDE_BITS-1:0] a;
		logic [SIDE_BITS-1:0] b;
		logic [C_BITS-1:0]    c;
		logic [PER_BITS-1:0]  per;
		logic                 zero;
	} tss_side_t;

endpackage

@@ rtl/core/tss_cos_pipe.sv @@
// Pipelined fixed-point cosine of the folded included angle, in Q30.
module tss_cos_pipe (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  tss_pkg::tss_item_t             in_item,
	input  logic [tss_pkg::ANGLE_BITS-1:0] in_angle,
	output logic                           out_valid,
	output tss_pkg::tss_item_t             out_item,
	output logic [tss_pkg::COS_BITS-1:0]   out_cos
);

	typedef struct packed {
		tss_pkg::tss_item_t item;
		logic [31:0]        x2;
		logic [31:0]        val;
	} hor_t;

	localparam int HSTAGES = 2 * tss_pkg::HORNER_STEPS;

	logic [tss_pkg::ANGLE_BITS-1:0] dsat;
	tss_pkg::tss_item_t             item_in;
	logic [tss_pkg::FOLD_BITS-1:0]  fold;

	logic                           v_s1, v_s2, v_s3, v_f1, v_f2;
	tss_pkg::tss_item_t             item_s1, item_s2, item_s3, item_f1, item_f2;
	logic [tss_pkg::FOLD_BITS-1:0]  fold_s1;
	logic [30:0]                    x_s2;
	logic [31:0]                    x2_s3;
	logic [31:0]                    p_f1;
	logic [30:0]                    cos_f2;
	logic [30:0]                    h_f1;

	logic                           hv_sh [HSTAGES];
	hor_t                           hd_sh [HSTAGES];
	hor_t                           hnxt  [HSTAGES];

	// Saturate to 180 degrees and fold onto the first quadrant.
	always_comb begin
		dsat           = (in_angle > tss_pkg::ANGLE_LIM) ? tss_pkg::ANGLE_LIM : in_angle;
		item_in        = in_item;
		item_in.obtuse = dsat > tss_pkg::ANGLE_HALF;
		fold = item_in.obtuse ? tss_pkg::FOLD_BITS'(tss_pkg::ANGLE_LIM - dsat)
		                      : tss_pkg::FOLD_BITS'(dsat);
	end

	for (genvar j = 0; j < HSTAGES; j++) begin : g_hor
		localparam int K = j / 2;
		hor_t src;
		if (j == 0) begin : g_first
			assign src = '{item: item_s3, x2: x2_s3, val: 32'(tss_pkg::ONE_Q30)};
		end else begin : g_next
			assign src = hd_sh[j-1];
		end
		if (j % 2 == 0) begin : g_mul
			logic [62:0] prod;
			always_comb begin
				prod          = 63'(src.x2) * 63'(src.val[30:0]);
				hnxt[j]       = src;
				hnxt[j].val   = 32'(prod >> 30);
			end
		end else begin : g_div
			logic [64:0] qm;
			logic [31:0] q;
			always_comb begin
				qm      = 65'(src.val) * 65'(tss_pkg::HORNER_MUL[K]);
				q       = 32'(qm >> tss_pkg::HORNER_SHIFT[K]);
				hnxt[j] = src;
				hnxt[j].val = (q >= 32'(tss_pkg::ONE_Q30)) ? 32'd0
				                                           : 32'(tss_pkg::ONE_Q30) - q;
			end
		end
	end

	assign h_f1 = 31'(p_f1 >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
			for (int i = 0; i < HSTAGES; i++) hv_sh[i] <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			hv_sh[0] <= v_s3;
			for (int i = 1; i < HSTAGES; i++) hv_sh[i] <= hv_sh[i-1];
			v_f1     <= hv_sh[HSTAGES-1];
			v_f2     <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_in;
			fold_s1 <= fold;
			item_s2 <= item_s1;
			x_s2    <= 31'((40'(fold_s1) * 40'(tss_pkg::RAD_Q30)) >> tss_pkg::FRAC_BITS);
			item_s3 <= item_s2;
			x2_s3   <= 32'((62'(x_s2) * 62'(x_s2)) >> 30);
			for (int i = 0; i < HSTAGES; i++) hd_sh[i] <= hnxt[i];
			item_f1 <= hd_sh[HSTAGES-1].item;
			p_f1    <= 32'((63'(hd_sh[HSTAGES-1].x2) * 63'(hd_sh[HSTAGES-1].val[30:0])) >> 30);
			item_f2 <= item_f1;
			cos_f2  <= (h_f1 >= tss_pkg::ONE_Q30) ? 31'd0 : tss_pkg::ONE_Q30 - h_f1;
		end
	end

	assign out_valid = v_f2;
	assign out_item  = item_f2;
	assign out_cos   = cos_f2;

endmodule

@@ rtl/core/tss_sqrt_pipe.sv @@
// Pipelined integer square root of a 48-bit value, four root bits per stage.
module tss_sqrt_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [tss_pkg::RAD_BITS-1:0]  radicand,
	input  tss_pkg::tss_side_t            in_side,
	output logic                          out_valid,
	output logic [tss_pkg::ROOT_BITS-1:0] root,
	output tss_pkg::tss_side_t            out_side
);

	localparam int STAGES = tss_pkg::ROOT_BITS / 4;

	typedef struct packed {
		logic [25:0]                   rem;
		logic [tss_pkg::ROOT_BITS-1:0] root;
		logic [tss_pkg::RAD_BITS-1:0]  rest;
		tss_pkg::tss_side_t            side;
	} sq_t;

	// Four steps of the digit-by-digit method: bring down two bits and try
	// subtracting four times the partial root plus one.
	function automatic sq_t step4(input sq_t s);
		sq_t         r;
		logic [27:0] r2;
		logic [27:0] trial;
		r = s;
		for (int k = 0; k < 4; k++) begin
			r2    = {r.rem, r.rest[tss_pkg::RAD_BITS-1 -: 2]};
			trial = {2'b00, r.root, 2'b01};
			if (r2 >= trial) begin
				r.rem  = 26'(r2 - trial);
				r.root = {r.root[tss_pkg::ROOT_BITS-2:0], 1'b1};
			end else begin
				r.rem  = 26'(r2);
				r.root = {r.root[tss_pkg::ROOT_BITS-2:0], 1'b0};
			end
			r.rest = {r.rest[tss_pkg::RAD_BITS-3:0], 2'b00};
		end
		return r;
	endfunction

	logic v_sq [STAGES];
	sq_t  d_sq [STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STAGES; i++) v_sq[i] <= 1'b0;
		end else if (en) begin
			v_sq[0] <= in_valid;
			for (int i = 1; i < STAGES; i++) v_sq[i] <= v_sq[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_sq[0] <= step4('{rem: '0, root: '0, rest: radicand, side: in_side});
			for (int i = 1; i < STAGES; i++) d_sq[i] <= step4(d_sq[i-1]);
		end
	end

	assign out_valid = v_sq[STAGES-1];
	assign root      = d_sq[STAGES-1].root;
	assign out_side  = d_sq[STAGES-1].side;

endmodule

@@ rtl/core/triangle_sas_solver_unit.sv @@
// Top level of the side-angle-side triangle solver: third side, perimeter and area.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds only while the output item is valid and stalled.
// Reset: arst_n clears every valid bit at once; payload registers are not reset.
// The pipeline includes the 17-stage cosine pipeline and the two 6-stage root pipelines.
module triangle_sas_solver_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tss_pkg::SIDE_BITS-1:0]   side_a,
	input  logic [tss_pkg::SIDE_BITS-1:0]   side_b,
	input  logic [tss_pkg::ANGLE_BITS-1:0]  included_angle,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tss_pkg::C_BITS-1:0]      side_c,
	output logic [tss_pkg::PER_BITS-1:0]    perimeter_out,
	output logic [tss_pkg::AREA_BITS-1:0]   area_out
);

	// The pipeline moves whenever the output register is free or being taken.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Cosine of the folded angle, with the sides and the obtuse flag riding along.
	logic                          cv;
	tss_pkg::tss_item_t            citem;
	logic [tss_pkg::COS_BITS-1:0]  ccos;

	tss_cos_pipe u_cos (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_item  ('{a: side_a, b: side_b, obtuse: 1'b0}),
		.in_angle (included_angle),
		.out_valid(cv),
		.out_item (citem),
		.out_cos  (ccos)
	);

	// Law of cosines: products first, then the rounded cross term, then c squared.
	logic                  v_s1, v_s2, v_s3, v_s4;
	tss_pkg::tss_item_t    item_s1, item_s2, item_s3, item_s4;
	logic [31:0]           ab_s1, aa_s1, bb_s1;
	logic [30:0]           cos_s1;
	logic [62:0]           mc_s2;
	logic [32:0]           ss_s2, ss_s3;
	logic [31:0]           m_s3;
	logic [33:0]           c2_s4;
	logic [32:0]           m2;
	logic [33:0]           c2;

	always_comb begin
		m2 = {m_s3, 1'b0};
		if (item_s3.obtuse) begin
			c2 = 34'(ss_s3) + 34'(m2);
		end else begin
			c2 = (m2 >= ss_s3) ? 34'd0 : 34'(ss_s3 - m2);
		end
	end

	// First square root gives the third side.
	logic                          rv1;
	logic [tss_pkg::ROOT_BITS-1:0] root1;
	tss_pkg::tss_side_t            side1;

	tss_sqrt_pipe u_sqrt_c (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.radicand (48'(c2_s4)),
		.in_side  ('{a: item_s4.a, b: item_s4.b, c: '0, per: '0, zero: 1'b0}),
		.out_valid(rv1),
		.root     (root1),
		.out_side (side1)
	);

	// Heron's formula in product form: X = (a+b)^2 - c^2, Y = c^2 - (a-b)^2,
	// and the area is the root of X*Y scaled down by 2^20, taken exactly.
	logic                  v_s5, v_s6, v_s7, v_s8, v_s9;
	tss_pkg::tss_side_t    side_s5, side_s6, side_s7, side_s8, side_s9;
	logic [tss_pkg::C_BITS-1:0]    c1;
	logic [16:0]           sum_s5;
	logic [15:0]           diff_s5;
	logic [33:0]           csq_s6, sumsq_s6;
	logic [31:0]           diffsq_s6;
	logic [33:0]           x_s7, y_s7;
	logic [33:0]           xd;
	logic [47:0]           hi_s8, prod_s9;
	logic [53:0]           lo_s8;

	assign c1 = root1[tss_pkg::C_BITS-1:0];
	assign xd = sumsq_s6 - csq_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= cv;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= rv1;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= citem;
			cos_s1  <= ccos;
			ab_s1   <= 32'(citem.a) * 32'(citem.b);
			aa_s1   <= 32'(citem.a) * 32'(citem.a);
			bb_s1   <= 32'(citem.b) * 32'(citem.b);

			item_s2 <= item_s1;
			mc_s2   <= 63'(ab_s1) * 63'(cos_s1);
			ss_s2   <= 33'(aa_s1) + 33'(bb_s1);

			item_s3 <= item_s2;
			ss_s3   <= ss_s2;
			m_s3    <= 32'((mc_s2 + 63'(64'd1 << 29)) >> 30);

			item_s4 <= item_s3;
			c2_s4   <= c2;

			side_s5 <= '{a: side1.a, b: side1.b, c: c1,
			             per: 18'(side1.a) + 18'(side1.b) + 18'(c1),
			             zero: side1.zero};
			sum_s5  <= 17'(side1.a) + 17'(side1.b);
			diff_s5 <= (side1.a >= side1.b) ? side1.a - side1.b : side1.b - side1.a;

			side_s6   <= side_s5;
			csq_s6    <= 34'(side_s5.c) * 34'(side_s5.c);
			sumsq_s6  <= 34'(sum_s5) * 34'(sum_s5);
			diffsq_s6 <= 32'(diff_s5) * 32'(diff_s5);

			// The area is zero when the Heron product rounds to zero or below.
			side_s7 <= '{a: side_s6.a, b: side_s6.b, c: side_s6.c, per: side_s6.per,
			             zero: (csq_s6 <= 34'(diffsq_s6)) || (xd == 34'd0)};
			x_s7    <= xd;
			y_s7    <= csq_s6 - 34'(diffsq_s6);

			side_s8 <= side_s7;
			hi_s8   <= 48'(x_s7[33:20]) * 48'(y_s7);
			lo_s8   <= 54'(x_s7[19:0]) * 54'(y_s7);

			side_s9 <= side_s8;
			prod_s9 <= hi_s8 + 48'(lo_s8 >> 20);
		end
	end

	// Second square root gives the area.
	logic                          rv2;
	logic [tss_pkg::ROOT_BITS-1:0] root2;
	tss_pkg::tss_side_t            side2;

	tss_sqrt_pipe u_sqrt_area (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s9),
		.radicand (prod_s9),
		.in_side  (side_s9),
		.out_valid(rv2),
		.root     (root2),
		.out_side (side2)
	);

	// Output register with area saturation.
	logic                            out_v_q;
	logic [tss_pkg::C_BITS-1:0]      side_c_q;
	logic [tss_pkg::PER_BITS-1:0]    per_q;
	logic [tss_pkg::AREA_BITS-1:0]   area_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= rv2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_c_q <= side2.c;
			per_q    <= side2.per;
			if (side2.zero) begin
				area_q <= '0;
			end else if (root2[tss_pkg::ROOT_BITS-1:tss_pkg::AREA_BITS] != '0) begin
				area_q <= '1;
			end else begin
				area_q <= root2[tss_pkg::AREA_BITS-1:0];
			end
		end
	end

	assign out_valid     = out_v_q;
	assign side_c        = side_c_q;
	assign perimeter_out = per_q;
	assign area_out      = area_q;

endmodule
